/* hw/rtl/cnlc_pkg.sv */
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and helpers for the C numeric literal classifier
// Character codes, phase/radix/kind/cause encodings, state and result
// structs, and the digit and exponent-mark decoders.
// ----------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

	localparam int VALUE_BITS = 64;   // accumulator width, 16..64
	localparam int OUT_BITS   = 64;   // width of the value port

	localparam logic [7:0] CASE_BIT = 8'h20;  // folds ASCII letters to lower case
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam logic [4:0] DIGIT_NONE = 5'd16;

	typedef enum logic [3:0] {
		PH_START      = 4'd0,
		PH_ZERO       = 4'd1,
		PH_INT        = 4'd2,
		PH_FRAC_FIRST = 4'd3,
		PH_FRAC       = 4'd4,
		PH_EXP_START  = 4'd5,
		PH_EXP        = 4'd6,
		PH_FSUF       = 4'd7,
		PH_ISUF       = 4'd8,
		PH_ERR        = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_BIN = 2'd1,
		RX_OCT = 2'd2,
		RX_HEX = 2'd3
	} radix_t;

	typedef enum logic [3:0] {
		K_ERR    = 4'd0,
		K_INT    = 4'd1,
		K_DOUBLE = 4'd2,
		K_FLOAT  = 4'd3,
		K_LONG   = 4'd4,
		K_LLONG  = 4'd5,
		K_ULONG  = 4'd6,
		K_ULLONG = 4'd7,
		K_UINT   = 4'd8
	} kind_t;

	typedef enum logic [3:0] {
		CE_NONE      = 4'd0,
		CE_PREFIX    = 4'd1,
		CE_OCTAL     = 4'd2,
		CE_BINARY    = 4'd3,
		CE_EXPONENT  = 4'd4,
		CE_SUFFIX    = 4'd5,
		CE_DUPLICATE = 4'd6,
		CE_FRACTION  = 4'd7,
		CE_FIRST     = 4'd8
	} cause_t;

	typedef struct packed {
		phase_t                  phase;
		radix_t                  radix;
		logic [VALUE_BITS-1:0]   acc;
		kind_t                   kind;
		cause_t                  cause;
		logic                    digits_seen;
	} state_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OUT_BITS-1:0]   value;
		cause_t                cause;
	} result_t;

	localparam state_t STATE_RST = '{
		phase:       PH_START,
		radix:       RX_DEC,
		acc:         '0,
		kind:        K_INT,
		cause:       CE_NONE,
		digits_seen: 1'b0
	};

	// digit value in the given radix, DIGIT_NONE if not a digit
	function automatic logic [4:0] digit_of(input logic [7:0] ch, input radix_t rx);
		logic [7:0] lc;
		logic [4:0] d;
		lc = ch | CASE_BIT;
		d  = DIGIT_NONE;
		if (ch >= CH_0 && ch <= CH_9)
			d = 5'(ch - CH_0);
		else if (rx == RX_HEX && lc >= CH_A && lc <= CH_F)
			d = 5'(lc - CH_A + 8'd10);
		if (rx == RX_BIN && d > 5'd1)
			d = DIGIT_NONE;
		if (rx == RX_OCT && d > 5'd7)
			d = DIGIT_NONE;
		return d;
	endfunction

	function automatic logic is_exp_mark(input logic [7:0] ch, input radix_t rx);
		logic [7:0] lc;
		lc = ch | CASE_BIT;
		return (lc == CH_P) || (rx != RX_HEX && lc == CH_E);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cnlc_step.sv */
// ----------------------------------------------------------------------------
// cnlc_step: per-character update of the literal scanner
// Combinational next-state logic for one character, plus the closing checks
// and result formatting used when the character ends the literal.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_step (
	input  wire logic [7:0]        ch,
	input  wire cnlc_pkg::state_t  cur,
	output cnlc_pkg::state_t       nxt,
	output cnlc_pkg::result_t      res
);

	localparam int VB = cnlc_pkg::VALUE_BITS;

	logic [7:0]    lc;
	logic [4:0]    dv;
	logic          is_dec;
	logic [VB-1:0] scaled;

	assign lc     = ch | cnlc_pkg::CASE_BIT;
	assign dv     = cnlc_pkg::digit_of(ch, cur.radix);
	assign is_dec = (ch >= cnlc_pkg::CH_0) && (ch <= cnlc_pkg::CH_9);

	// U/L suffix folding on the integer kind
	function automatic cnlc_pkg::state_t int_suffix(input cnlc_pkg::state_t s);
		cnlc_pkg::state_t n;
		n       = s;
		n.phase = cnlc_pkg::PH_ISUF;
		if (lc == cnlc_pkg::CH_L) begin
			unique case (s.kind)
				cnlc_pkg::K_INT:   n.kind = cnlc_pkg::K_LONG;
				cnlc_pkg::K_LONG:  n.kind = cnlc_pkg::K_LLONG;
				cnlc_pkg::K_UINT:  n.kind = cnlc_pkg::K_ULONG;
				cnlc_pkg::K_ULONG: n.kind = cnlc_pkg::K_ULLONG;
				default: begin
					n.phase = cnlc_pkg::PH_ERR;
					n.cause = cnlc_pkg::CE_DUPLICATE;
				end
			endcase
		end else if (lc == cnlc_pkg::CH_U) begin
			unique case (s.kind)
				cnlc_pkg::K_INT:   n.kind = cnlc_pkg::K_UINT;
				cnlc_pkg::K_LONG:  n.kind = cnlc_pkg::K_ULONG;
				cnlc_pkg::K_LLONG: n.kind = cnlc_pkg::K_ULLONG;
				default: begin
					n.phase = cnlc_pkg::PH_ERR;
					n.cause = cnlc_pkg::CE_DUPLICATE;
				end
			endcase
		end else begin
			n.phase = cnlc_pkg::PH_ERR;
			n.cause = cnlc_pkg::CE_SUFFIX;
		end
		return n;
	endfunction

	function automatic cnlc_pkg::state_t float_suffix(input cnlc_pkg::state_t s);
		cnlc_pkg::state_t n;
		n = s;
		if (lc == cnlc_pkg::CH_F) begin
			n.kind  = cnlc_pkg::K_FLOAT;
			n.phase = cnlc_pkg::PH_FSUF;
		end else if (lc == cnlc_pkg::CH_L || lc == cnlc_pkg::CH_I) begin
			n.phase = cnlc_pkg::PH_FSUF;
		end else begin
			n.phase = cnlc_pkg::PH_ERR;
			n.cause = cnlc_pkg::CE_SUFFIX;
		end
		return n;
	endfunction

	always_comb begin
		unique case (cur.radix)
			cnlc_pkg::RX_DEC: scaled = (cur.acc << 3) + (cur.acc << 1);
			cnlc_pkg::RX_BIN: scaled = cur.acc << 1;
			cnlc_pkg::RX_OCT: scaled = cur.acc << 3;
			cnlc_pkg::RX_HEX: scaled = cur.acc << 4;
		endcase
	end

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			cnlc_pkg::PH_START: begin
				if (ch == cnlc_pkg::CH_0) begin
					nxt.phase = cnlc_pkg::PH_ZERO;
				end else if (is_dec) begin
					nxt.radix = cnlc_pkg::RX_DEC;
					nxt.acc   = VB'(dv[3:0]);
					nxt.phase = cnlc_pkg::PH_INT;
				end else if (ch == cnlc_pkg::CH_DOT) begin
					nxt.radix = cnlc_pkg::RX_DEC;
					nxt.kind  = cnlc_pkg::K_DOUBLE;
					nxt.phase = cnlc_pkg::PH_FRAC_FIRST;
				end else begin
					nxt.phase = cnlc_pkg::PH_ERR;
					nxt.cause = cnlc_pkg::CE_FIRST;
				end
			end
			cnlc_pkg::PH_ZERO: begin
				if (lc == cnlc_pkg::CH_B) begin
					nxt.radix = cnlc_pkg::RX_BIN;
					nxt.phase = cnlc_pkg::PH_INT;
				end else if (lc == cnlc_pkg::CH_X) begin
					nxt.radix = cnlc_pkg::RX_HEX;
					nxt.phase = cnlc_pkg::PH_INT;
				end else if (ch >= cnlc_pkg::CH_0 && ch <= cnlc_pkg::CH_7) begin
					nxt.radix = cnlc_pkg::RX_OCT;
					nxt.acc   = VB'(ch[2:0]);
					nxt.phase = cnlc_pkg::PH_INT;
				end else if (ch == cnlc_pkg::CH_DOT) begin
					nxt.radix = cnlc_pkg::RX_DEC;
					nxt.kind  = cnlc_pkg::K_DOUBLE;
					nxt.phase = cnlc_pkg::PH_FRAC_FIRST;
				end else begin
					nxt.phase = cnlc_pkg::PH_ERR;
					nxt.cause = cnlc_pkg::CE_PREFIX;
				end
			end
			cnlc_pkg::PH_INT: begin
				if (!dv[4]) begin
					nxt.acc = scaled + VB'(dv[3:0]);
				end else if (cur.radix == cnlc_pkg::RX_BIN) begin
					nxt.phase = cnlc_pkg::PH_ERR;
					nxt.cause = cnlc_pkg::CE_BINARY;
				end else if (cur.radix == cnlc_pkg::RX_OCT) begin
					nxt.phase = cnlc_pkg::PH_ERR;
					nxt.cause = cnlc_pkg::CE_OCTAL;
				end else if (ch == cnlc_pkg::CH_DOT) begin
					nxt.kind  = cnlc_pkg::K_DOUBLE;
					nxt.phase = cnlc_pkg::PH_FRAC_FIRST;
				end else if (cnlc_pkg::is_exp_mark(ch, cur.radix)) begin
					nxt.kind        = cnlc_pkg::K_DOUBLE;
					nxt.digits_seen = 1'b0;
					nxt.phase       = cnlc_pkg::PH_EXP_START;
				end else begin
					nxt = int_suffix(cur);
				end
			end
			cnlc_pkg::PH_FRAC_FIRST, cnlc_pkg::PH_FRAC: begin
				if (!dv[4]) begin
					nxt.phase = cnlc_pkg::PH_FRAC;
				end else if (cnlc_pkg::is_exp_mark(ch, cur.radix)) begin
					nxt.digits_seen = 1'b0;
					nxt.phase       = cnlc_pkg::PH_EXP_START;
				end else begin
					nxt = float_suffix(cur);
				end
			end
			cnlc_pkg::PH_EXP_START, cnlc_pkg::PH_EXP: begin
				if (is_dec) begin
					nxt.digits_seen = 1'b1;
					nxt.phase       = cnlc_pkg::PH_EXP;
				end else if (cur.phase == cnlc_pkg::PH_EXP_START &&
						(ch == cnlc_pkg::CH_PLUS || ch == cnlc_pkg::CH_MINUS)) begin
					nxt.phase = cnlc_pkg::PH_EXP;
				end else if (!cur.digits_seen) begin
					nxt.phase = cnlc_pkg::PH_ERR;
					nxt.cause = cnlc_pkg::CE_EXPONENT;
				end else begin
					nxt = float_suffix(cur);
				end
			end
			cnlc_pkg::PH_FSUF: begin
				nxt.phase = cnlc_pkg::PH_ERR;
				if (lc == cnlc_pkg::CH_F || lc == cnlc_pkg::CH_L || lc == cnlc_pkg::CH_I)
					nxt.cause = cnlc_pkg::CE_DUPLICATE;
				else
					nxt.cause = cnlc_pkg::CE_SUFFIX;
			end
			cnlc_pkg::PH_ISUF: begin
				nxt = int_suffix(cur);
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// closing checks: a literal that ends on its dot, or an exponent without digits
	always_comb begin
		cnlc_pkg::phase_t ph;
		cnlc_pkg::cause_t ce;
		ph = nxt.phase;
		ce = nxt.cause;
		if (nxt.phase == cnlc_pkg::PH_FRAC_FIRST) begin
			ph = cnlc_pkg::PH_ERR;
			ce = cnlc_pkg::CE_FRACTION;
		end else if (nxt.phase == cnlc_pkg::PH_EXP_START ||
				(nxt.phase == cnlc_pkg::PH_EXP && !nxt.digits_seen)) begin
			ph = cnlc_pkg::PH_ERR;
			ce = cnlc_pkg::CE_EXPONENT;
		end
		if (ph == cnlc_pkg::PH_ERR) begin
			res.kind  = cnlc_pkg::K_ERR;
			res.value = '0;
			res.cause = ce;
		end else begin
			res.kind  = nxt.kind;
			res.cause = cnlc_pkg::CE_NONE;
			if (nxt.kind == cnlc_pkg::K_DOUBLE || nxt.kind == cnlc_pkg::K_FLOAT)
				res.value = '0;
			else
				res.value = cnlc_pkg::OUT_BITS'(nxt.acc);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/c_numeric_literal_classifier.sv */
// Result path: a final character passes the input stage (s1), then the result register (res_q).
// Throughput: one character per cycle unless a blocked result stalls input; the scanner state is registered.
// A result that waits on out_ready stalls input only when the next final char arrives.
// Reset (arst_n low, asynchronous): input and result stages empty, scanner at the
// start of a literal. After each final character the scanner returns to that state.
// ----------------------------------------------------------------------------
// c_numeric_literal_classifier: C numeric literal lexer
// Scans one preprocessing number per sequence of characters and reports its
// kind, integer value and error cause on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module c_numeric_literal_classifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  character_code,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       kind,
	output logic [63:0]      value,
	output logic [3:0]       error_cause
);

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               last_s1;
	logic               go_s1;
	logic               in_xfer;
	cnlc_pkg::state_t   state_q;
	cnlc_pkg::state_t   state_nxt;
	cnlc_pkg::result_t  res_nxt;
	cnlc_pkg::result_t  res_q;
	logic               out_valid_q;

	// stage 1 drains unless it holds a final char and the result slot is full and not being taken
	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1   <= character_code;
			last_s1 <= is_last;
		end
	end

	cnlc_step u_step (
		.ch  (ch_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnlc_pkg::STATE_RST;
		end else if (go_s1) begin
			state_q <= last_s1 ? cnlc_pkg::STATE_RST : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign value       = res_q.value;
	assign error_cause = res_q.cause;

`ifndef SYNTHESIS
	a_err_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cnlc_pkg::K_ERR |-> error_cause != cnlc_pkg::CE_NONE)
		else $error("error result without a cause");

	a_ok_no_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != cnlc_pkg::K_ERR |-> error_cause == cnlc_pkg::CE_NONE)
		else $error("cause reported on a good result");

	a_float_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == cnlc_pkg::K_DOUBLE || kind == cnlc_pkg::K_FLOAT)
		|-> value == '0)
		else $error("floating kind with nonzero value");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && last_s1 |=> state_q == cnlc_pkg::STATE_RST)
		else $error("scanner not back at start after final char");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
